[rtl/cartridge_bank_and_lcd_capture_defines.svh]
// ----------------------------------------------------------------------------
// Cartridge bank and LCD capture: assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_AND_LCD_CAPTURE_DEFINES_SVH
`define CARTRIDGE_BANK_AND_LCD_CAPTURE_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define CBL_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define CBL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cbl_pkg.sv]
// ----------------------------------------------------------------------------
// Cartridge bank and LCD capture package
// Constants, reset values and the result word type shared by all modules.
// ----------------------------------------------------------------------------
package cbl_pkg;

    // Display frame and row geometry
    localparam int FRAME_BYTES = 163840;
    localparam int ROW_BYTES   = 480;
    localparam int CNT_W       = 18;
    localparam int ROW_W       = $clog2(ROW_BYTES);

    // Display interface codes
    localparam logic [7:0]  CMD_MEMORY_WRITE = 8'h2C;
    localparam logic [7:0]  MODE_COMMAND     = 8'h00;
    localparam logic [7:0]  MODE_DATA        = 8'h02;
    localparam logic [15:0] DISPLAY_PORT     = 16'h00FF;

    // Mode register reset values
    localparam logic [7:0] MODE0_RESET = 8'h00;
    localparam logic [7:0] MODE1_RESET = 8'h00;
    localparam logic [7:0] MODE2_RESET = 8'h00;
    localparam logic [7:0] MODE3_RESET = 8'h80;

    // Mode register indexes
    localparam logic [1:0] MODE_IDX_DISPLAY = 2'd1;
    localparam logic [1:0] MODE_IDX_PRG_LOW = 2'd2;
    localparam logic [1:0] MODE_IDX_PRG_HI  = 2'd3;

    // One result word
    typedef struct packed {
        logic [7:0]       prg_bank_low;
        logic [7:0]       prg_bank_high;
        logic [2:0]       chr_bank;
        logic             mirror_horizontal;
        logic [7:0]       led_value;
        logic             fb_write;
        logic [CNT_W-1:0] fb_address;
        logic [7:0]       fb_byte;
        logic             row_done;
    } result_t;

endpackage

[rtl/cbl_core.sv]
// ----------------------------------------------------------------------------
// Mapper and display state core
// Holds mapper and display state, updates it on each word taken and forms
// the result word from the updated state.
// ----------------------------------------------------------------------------
module cbl_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  logic [15:0]      address,
    input  logic [7:0]       data,
    output cbl_pkg::result_t result
);
    import cbl_pkg::*;

    logic [7:0]       mode_reg [4];
    logic [7:0]       mode_next [4];
    logic [7:0]       latch_reg, latch_next;
    logic [7:0]       led_reg, led_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [CNT_W:0]   cnt_inc;
    logic [ROW_W:0]   row_inc;
    logic             frame_wrap;
    logic             row_wrap;
    logic [3:0]       page;
    logic             fb_hit;

    assign page       = address[15:12];
    assign cnt_inc    = {1'b0, cnt_reg} + (CNT_W+1)'(1);
    assign row_inc    = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign frame_wrap = cnt_inc >= (CNT_W+1)'(FRAME_BYTES);
    assign row_wrap   = row_inc >= (ROW_W+1)'(ROW_BYTES);

    // Decode the write and form next state
    always_comb begin
        mode_next  = mode_reg;
        latch_next = latch_reg;
        led_next   = led_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        fb_hit     = 1'b0;
        if (address == DISPLAY_PORT) begin
            if (mode_reg[MODE_IDX_DISPLAY] == MODE_COMMAND) begin
                cmd_next = data;
                cnt_next = '0;
                row_next = '0;
            end else if (mode_reg[MODE_IDX_DISPLAY] == MODE_DATA &&
                         cmd_reg == CMD_MEMORY_WRITE) begin
                fb_hit = 1'b1;
                if (frame_wrap) begin
                    cnt_next = '0;
                    row_next = '0;
                end else begin
                    cnt_next = cnt_inc[CNT_W-1:0];
                    row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
                end
            end
        end else if (page == 4'h6 || page == 4'h7) begin
            if (address[10:0] == 11'd0) begin
                mode_next[address[12:11]] = data;
            end
        end else if (page >= 4'h8 && page <= 4'hB) begin
            led_next = data;
        end else if (page >= 4'hC) begin
            latch_next = data;
        end
    end

    // Form the result word from the updated state
    always_comb begin
        result.prg_bank_low      = {mode_next[MODE_IDX_PRG_LOW][7:3], latch_next[2:0]};
        result.prg_bank_high     = {mode_next[MODE_IDX_PRG_HI][7:3], 3'b111};
        result.chr_bank          = latch_next[7:5];
        result.mirror_horizontal = mode_next[MODE_IDX_PRG_HI][5];
        result.led_value         = led_next;
        result.fb_write          = fb_hit;
        result.fb_address        = fb_hit ? cnt_reg : '0;
        result.fb_byte           = fb_hit ? data : 8'd0;
        result.row_done          = fb_hit && (row_next == '0);
    end

    // Hold state, advance on each word taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg[0] <= MODE0_RESET;
            mode_reg[1] <= MODE1_RESET;
            mode_reg[2] <= MODE2_RESET;
            mode_reg[3] <= MODE3_RESET;
            latch_reg   <= 8'd0;
            led_reg     <= 8'd0;
            cmd_reg     <= 8'd0;
            cnt_reg     <= '0;
            row_reg     <= '0;
        end else if (take) begin
            mode_reg    <= mode_next;
            latch_reg   <= latch_next;
            led_reg     <= led_next;
            cmd_reg     <= cmd_next;
            cnt_reg     <= cnt_next;
            row_reg     <= row_next;
        end
    end

endmodule

[rtl/cbl_out_reg.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one result word toward the receiver and grants the upstream stage a
// move whenever the register is empty or being drained.
// ----------------------------------------------------------------------------
module cbl_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load_valid,
    input  cbl_pkg::result_t load_word,
    output logic             take,
    input  logic             m_ready,
    output logic             m_valid,
    output cbl_pkg::result_t m_word
);
    import cbl_pkg::*;

    logic    valid_reg;
    result_t word_reg;

    // Move a word in when the register frees up this cycle
    assign take    = load_valid && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_word  = word_reg;

    // Track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Load the payload
    always_ff @(posedge aclk) begin
        if (take) begin
            word_reg <= load_word;
        end
    end

endmodule

[rtl/cartridge_bank_and_lcd_capture.sv]
// ----------------------------------------------------------------------------
// Cartridge bank mapper with LCD frame-buffer capture
//
// Input channel (s_): one CPU bus write word, address and data, per transfer.
// Output channel (m_): one result word per input word: both 16K program banks,
// the 8K character bank, mirroring, the LED byte and any frame-buffer byte
// write caused by a write to the display port.
// A word accepted enters the input register; the state update and result are
// formed combinationally from it, and the result is registered in the output
// register before it appears on m_. Throughput: one word per cycle while the
// receiver takes each result, set by the single register-to-register pass
// through the decode and counter update.
// s_ready stays high while the input register is empty or moving forward, so
// a new word is taken even while a result waits on the output.
// Reset (aresetn low, synchronous) empties both registers and loads the mode
// registers, latch, LED byte, display command and counters with their reset
// values. When the receiver stalls the result holds, the input register
// fills, and s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module cartridge_bank_and_lcd_capture (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [15:0]               s_address,
    input  logic [7:0]                s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_prg_bank_low,
    output logic [7:0]                m_prg_bank_high,
    output logic [2:0]                m_chr_bank,
    output logic                      m_mirror_horizontal,
    output logic [7:0]                m_led_value,
    output logic                      m_fb_write,
    output logic [cbl_pkg::CNT_W-1:0] m_fb_address,
    output logic [7:0]                m_fb_byte,
    output logic                      m_row_done
);
    import cbl_pkg::*;

    logic        in_valid_reg;
    logic [15:0] in_address_reg;
    logic [7:0]  in_data_reg;
    logic        take;
    result_t     core_word;
    result_t     out_word;

    // Accept when the input register is empty or moving forward
    assign s_ready = !in_valid_reg || take;

    // Track input register occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (take) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture the bus write word
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_address_reg <= s_address;
            in_data_reg    <= s_data;
        end
    end

    cbl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .address (in_address_reg),
        .data    (in_data_reg),
        .result  (core_word)
    );

    cbl_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .load_word  (core_word),
        .take       (take),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_word     (out_word)
    );

    // Spread the result word over the ports
    assign m_prg_bank_low      = out_word.prg_bank_low;
    assign m_prg_bank_high     = out_word.prg_bank_high;
    assign m_chr_bank          = out_word.chr_bank;
    assign m_mirror_horizontal = out_word.mirror_horizontal;
    assign m_led_value         = out_word.led_value;
    assign m_fb_write          = out_word.fb_write;
    assign m_fb_address        = out_word.fb_address;
    assign m_fb_byte           = out_word.fb_byte;
    assign m_row_done          = out_word.row_done;

endmodule

[rtl/cbl_checker.sv]
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports and flags result words that break the
// handshake, carry inconsistent frame-buffer fields or a wrong upper program bank.
// ----------------------------------------------------------------------------
`include "cartridge_bank_and_lcd_capture_defines.svh"

module cbl_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [7:0]                m_prg_bank_high,
    input logic                      m_fb_write,
    input logic [cbl_pkg::CNT_W-1:0] m_fb_address,
    input logic [7:0]                m_fb_byte,
    input logic                      m_row_done
);
    import cbl_pkg::*;

    // Stalled result word stays valid and holds its frame-buffer address and byte
    `CBL_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_fb_address) && $stable(m_fb_byte), "stalled result word changed")

    // Frame-buffer fields are zero without a frame-buffer write
    `CBL_ASSERT_ALWAYS(a_fb_idle, aclk, aresetn, !m_valid || m_fb_write || (m_fb_address == '0 && m_fb_byte == 8'd0 && !m_row_done), "frame-buffer fields set without a write")

    // Frame-buffer address stays inside the frame
    `CBL_ASSERT_ALWAYS(a_fb_range, aclk, aresetn, !m_valid || ({1'b0, m_fb_address} < (CNT_W+1)'(FRAME_BYTES)), "frame-buffer address beyond frame")

    // An empty output never blocks the input
    `CBL_ASSERT_ALWAYS(a_ready_empty, aclk, aresetn, m_valid || s_ready, "input stalled with empty output")

    // Upper program bank low bits are fixed
    `CBL_ASSERT_ALWAYS(a_prg_high, aclk, aresetn, !m_valid || (m_prg_bank_high[2:0] == 3'b111), "upper program bank low bits not set")

endmodule

bind cartridge_bank_and_lcd_capture cbl_checker u_cbl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_prg_bank_high (m_prg_bank_high),
    .m_fb_write      (m_fb_write),
    .m_fb_address    (m_fb_address),
    .m_fb_byte       (m_fb_byte),
    .m_row_done      (m_row_done)
);

[verif/cbl_bus_monitor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bus write monitor for the cartridge bank and LCD capture block
// Watches both channels. Each accepted bus write word goes through a local
// model of the mapper and display port, and the mapping word that it must
// produce is queued. Each accepted result word is compared field by field
// with the oldest queued mapping.
// ----------------------------------------------------------------------------
module cbl_bus_monitor (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [15:0]               s_address,
    input  logic [7:0]                s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [7:0]                m_prg_bank_low,
    input  logic [7:0]                m_prg_bank_high,
    input  logic [2:0]                m_chr_bank,
    input  logic                      m_mirror_horizontal,
    input  logic [7:0]                m_led_value,
    input  logic                      m_fb_write,
    input  logic [cbl_pkg::CNT_W-1:0] m_fb_address,
    input  logic [7:0]                m_fb_byte,
    input  logic                      m_row_done,
    output int                        error_count,
    output int                        pending_count,
    output int                        results_checked,
    output int                        fb_bytes_seen,
    output int                        rows_seen
);
    import cbl_pkg::*;

    // Local copy of the block state
    logic [7:0]       mode_q [4];
    logic [7:0]       latch_q;
    logic [7:0]       led_q;
    logic [7:0]       cmd_q;
    logic [CNT_W-1:0] cnt_q;
    logic [ROW_W-1:0] row_q;

    result_t pending_mappings [$];
    int      errors;
    int      checked;
    int      fb_bytes;
    int      rows;

    // Apply one bus write to the local state and form the mapping word
    function automatic result_t apply_bus_write(input logic [15:0] addr,
                                                input logic [7:0] value);
        result_t          r;
        logic [3:0]       page;
        logic [CNT_W-1:0] next_cnt;
        logic [ROW_W-1:0] next_row;
        r    = '0;
        page = addr[15:12];
        if (addr == DISPLAY_PORT) begin
            if (mode_q[MODE_IDX_DISPLAY] == MODE_COMMAND) begin
                cmd_q = value;
                cnt_q = '0;
                row_q = '0;
            end else if (mode_q[MODE_IDX_DISPLAY] == MODE_DATA
                         && cmd_q == CMD_MEMORY_WRITE) begin
                r.fb_write   = 1'b1;
                r.fb_address = cnt_q;
                r.fb_byte    = value;
                next_cnt     = cnt_q + 1'b1;
                next_row     = row_q + 1'b1;
                // wrap at the end of the frame, restarting the row too
                if (next_cnt >= FRAME_BYTES) begin
                    next_cnt = '0;
                    next_row = '0;
                end
                if (next_row >= ROW_BYTES)
                    next_row = '0;
                r.row_done = (next_row == '0);
                cnt_q      = next_cnt;
                row_q      = next_row;
            end
        end else if (page == 4'h6 || page == 4'h7) begin
            // only the four aligned offsets load a mode register
            if (addr[10:0] == '0)
                mode_q[{addr[12], addr[11]}] = value;
        end else if (page >= 4'h8 && page <= 4'hB) begin
            led_q = value;
        end else if (page >= 4'hC) begin
            latch_q = value;
        end
        r.prg_bank_low      = {mode_q[MODE_IDX_PRG_LOW][7:3], latch_q[2:0]};
        r.prg_bank_high     = {mode_q[MODE_IDX_PRG_HI][7:3], 3'b111};
        r.chr_bank          = latch_q[7:5];
        r.mirror_horizontal = mode_q[MODE_IDX_PRG_HI][5];
        r.led_value         = led_q;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Pop the oldest mapping and compare it with the word on m_
    task automatic check_result();
        result_t want;
        result_t got;
        got = {m_prg_bank_low, m_prg_bank_high, m_chr_bank, m_mirror_horizontal,
               m_led_value, m_fb_write, m_fb_address, m_fb_byte, m_row_done};
        if (pending_mappings.size() == 0) begin
            $error("result word 0x%0h arrived with no bus write pending", got);
            errors++;
        end else begin
            want = pending_mappings.pop_front();
            compare_field("prg_bank_low", 32'(want.prg_bank_low),
                          32'(got.prg_bank_low));
            compare_field("prg_bank_high", 32'(want.prg_bank_high),
                          32'(got.prg_bank_high));
            compare_field("chr_bank", 32'(want.chr_bank), 32'(got.chr_bank));
            compare_field("mirror_horizontal", 32'(want.mirror_horizontal),
                          32'(got.mirror_horizontal));
            compare_field("led_value", 32'(want.led_value), 32'(got.led_value));
            compare_field("fb_write", 32'(want.fb_write), 32'(got.fb_write));
            compare_field("fb_address", 32'(want.fb_address),
                          32'(got.fb_address));
            compare_field("fb_byte", 32'(want.fb_byte), 32'(got.fb_byte));
            compare_field("row_done", 32'(want.row_done), 32'(got.row_done));
            checked++;
            if (want.fb_write)
                fb_bytes++;
            if (want.row_done)
                rows++;
        end
    endtask

    initial begin
        errors   = 0;
        checked  = 0;
        fb_bytes = 0;
        rows     = 0;
    end

    // Track both channels at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_q[0] = MODE0_RESET;
            mode_q[1] = MODE1_RESET;
            mode_q[2] = MODE2_RESET;
            mode_q[3] = MODE3_RESET;
            latch_q   = '0;
            led_q     = '0;
            cmd_q     = '0;
            cnt_q     = '0;
            row_q     = '0;
            pending_mappings.delete();
        end else begin
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready)
                pending_mappings.push_back(apply_bus_write(s_address, s_data));
        end
        error_count     <= errors;
        pending_count   <= pending_mappings.size();
        results_checked <= checked;
        fb_bytes_seen   <= fb_bytes;
        rows_seen       <= rows;
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the cartridge bank mapper with LCD frame-buffer capture
// Drives bus write words: a directed pass over the address decode and the
// display port modes, then random traffic built mostly from display
// command/data sequences, under three idle profiles. The bus monitor
// checks every result word.
// ----------------------------------------------------------------------------
module tb;
    import cbl_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1400;

    // Mode register addresses
    localparam logic [15:0] MODE0_ADDR   = 16'h6000;
    localparam logic [15:0] DISP_MODE    = 16'h6800;
    localparam logic [15:0] PRG_LOW_ADDR = 16'h7000;
    localparam logic [15:0] PRG_HI_ADDR  = 16'h7800;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic [15:0]         s_address = '0;
    logic [7:0]          s_data    = '0;
    logic                m_ready   = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic [7:0]          m_prg_bank_low;
    logic [7:0]          m_prg_bank_high;
    logic [2:0]          m_chr_bank;
    logic                m_mirror_horizontal;
    logic [7:0]          m_led_value;
    logic                m_fb_write;
    logic [CNT_W-1:0]    m_fb_address;
    logic [7:0]          m_fb_byte;
    logic                m_row_done;

    int error_count;
    int pending_count;
    int results_checked;
    int fb_bytes_seen;
    int rows_seen;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int quiet_left  = 0;
    int words_sent  = 0;
    int stall_run   = 0;

    cartridge_bank_and_lcd_capture DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_address           (s_address),
        .s_data              (s_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_prg_bank_low      (m_prg_bank_low),
        .m_prg_bank_high     (m_prg_bank_high),
        .m_chr_bank          (m_chr_bank),
        .m_mirror_horizontal (m_mirror_horizontal),
        .m_led_value         (m_led_value),
        .m_fb_write          (m_fb_write),
        .m_fb_address        (m_fb_address),
        .m_fb_byte           (m_fb_byte),
        .m_row_done          (m_row_done)
    );

    cbl_bus_monitor u_monitor (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_address           (s_address),
        .s_data              (s_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_prg_bank_low      (m_prg_bank_low),
        .m_prg_bank_high     (m_prg_bank_high),
        .m_chr_bank          (m_chr_bank),
        .m_mirror_horizontal (m_mirror_horizontal),
        .m_led_value         (m_led_value),
        .m_fb_write          (m_fb_write),
        .m_fb_address        (m_fb_address),
        .m_fb_byte           (m_fb_byte),
        .m_row_done          (m_row_done),
        .error_count         (error_count),
        .pending_count       (pending_count),
        .results_checked     (results_checked),
        .fb_bytes_seen       (fb_bytes_seen),
        .rows_seen           (rows_seen)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Throttle the receiver; now and then open a stretch with no idling
    always @(posedge aclk) begin
        if (quiet_left > 0)
            quiet_left <= quiet_left - 1;
        else if ($urandom_range(299) == 0)
            quiet_left <= 40 + $urandom_range(60);
        m_ready <= (quiet_left > 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    // Present one word and hold it until it is accepted
    task automatic send_word(input logic [15:0] addr, input logic [7:0] value);
        while (quiet_left == 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_address <= addr;
        s_data    <= value;
        do
            @(posedge aclk);
        while (!s_ready);
        words_sent++;
    endtask

    // One random word; returns 1 unless it is an unaligned mode window write or a random-address word
    task automatic send_random_word(output bit counts);
        int          pick;
        logic [15:0] addr;
        pick   = $urandom_range(99);
        counts = 1'b1;
        if (pick < 8) begin
            case ($urandom_range(2))
                0:       send_word(DISP_MODE, MODE_COMMAND);
                1:       send_word(DISP_MODE, MODE_DATA);
                default: send_word(DISP_MODE, 8'($urandom));
            endcase
        end else if (pick < 16) begin
            case ($urandom_range(2))
                0:       send_word(MODE0_ADDR, 8'($urandom));
                1:       send_word(PRG_LOW_ADDR, 8'($urandom));
                default: send_word(PRG_HI_ADDR, 8'($urandom));
            endcase
        end else if (pick < 22) begin
            // unaligned offset inside the mode register window
            addr = {3'b011, 13'($urandom)};
            if (addr[10:0] == '0)
                addr[0] = 1'b1;
            send_word(addr, 8'($urandom));
            counts = 1'b0;
        end else if (pick < 32) begin
            send_word({2'b10, 14'($urandom)}, 8'($urandom));
        end else if (pick < 42) begin
            send_word({2'b11, 14'($urandom)}, 8'($urandom));
        end else if (pick < 80) begin
            send_word(DISPLAY_PORT, 8'($urandom));
        end else begin
            send_word(16'($urandom), 8'($urandom));
            counts = 1'b0;
        end
    endtask

    // Mostly display command/data sequences with random content, some noise
    task automatic run_random(input int target);
        int done;
        int burst;
        bit counts;
        done = 0;
        while (done < target) begin
            if ($urandom_range(7) == 0) begin
                if ($urandom_range(5) != 0) begin
                    send_word(DISP_MODE, MODE_COMMAND);
                    send_word(DISPLAY_PORT, ($urandom_range(4) == 0) ?
                              8'($urandom) : CMD_MEMORY_WRITE);
                    done += 2;
                end
                send_word(DISP_MODE, MODE_DATA);
                burst = ($urandom_range(9) == 0) ? $urandom_range(300, 700) :
                        $urandom_range(1, 30);
                done += burst + 1;
                repeat (burst) begin
                    if ($urandom_range(9) == 0)
                        send_random_word(counts);
                    send_word(DISPLAY_PORT, 8'($urandom));
                end
            end else begin
                send_random_word(counts);
                if (counts)
                    done++;
            end
        end
    endtask

    // Decode edges, every display mode and command, and the reset mapping
    task automatic run_directed();
        send_word(16'h0000, 8'h00);
        send_word(PRG_HI_ADDR, 8'h00);
        send_word(PRG_HI_ADDR, 8'hFF);
        send_word(PRG_LOW_ADDR, 8'hFF);
        send_word(MODE0_ADDR, 8'hA5);
        send_word(16'h6001, 8'h00);
        send_word(16'h7FFF, 8'h00);
        send_word(16'h77FF, 8'h00);
        send_word(16'h8000, 8'hFF);
        send_word(16'hBFFF, 8'h5A);
        send_word(16'hC000, 8'hFF);
        send_word(16'hFFFF, 8'h1F);
        send_word(16'h5FFF, 8'hFF);
        send_word(16'h00FE, 8'hFF);
        send_word(16'h0100, 8'hFF);
        send_word(DISP_MODE, 8'hFF);
        send_word(DISPLAY_PORT, CMD_MEMORY_WRITE);
        send_word(DISP_MODE, MODE_COMMAND);
        send_word(DISPLAY_PORT, 8'h12);
        send_word(DISP_MODE, MODE_DATA);
        send_word(DISPLAY_PORT, 8'h77);
        send_word(DISP_MODE, MODE_COMMAND);
        send_word(DISPLAY_PORT, CMD_MEMORY_WRITE);
        send_word(DISP_MODE, MODE_DATA);
        send_word(DISPLAY_PORT, 8'h00);
        send_word(DISPLAY_PORT, 8'hFF);
        send_word(DISP_MODE, 8'h01);
        send_word(DISPLAY_PORT, 8'h33);
    endtask

    // Stimulus and verdict
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 36;
        rx_idle_pct = 53;
        run_directed();
        run_random(RANDOM_ITEMS / 3);

        tx_idle_pct = 53;
        rx_idle_pct = 36;
        run_random(RANDOM_ITEMS / 3);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        s_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bus writes under three idle profiles.", words_sent);
        $display("Checked %0d result words: %0d frame-buffer bytes, %0d completed rows.",
                 results_checked, fb_bytes_seen, rows_seen);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: end the run when neither channel moves for too long
    initial begin
        while (stall_run < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_run = 0;
            else
                stall_run++;
        end
        $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule

[cartridge_bank_and_lcd_capture.f]
+incdir+rtl
rtl/cbl_pkg.sv
rtl/cbl_core.sv
rtl/cbl_out_reg.sv
rtl/cartridge_bank_and_lcd_capture.sv
rtl/cbl_checker.sv
verif/cbl_bus_monitor.sv
verif/tb.sv
